[design/qvr_pkg.sv]
// Shared widths, constants and word types for the quaternion vector rotator.
package qvr_pkg;

  // Field widths of the data path
  localparam int QUAT_W = 16;
  localparam int VEC_W = 32;
  localparam int QFRAC = QUAT_W - 2;

  // Internal widths: pairwise product, exact matrix entry, rounded entry,
  // entry times vector component, row sum, rounded row, row plus offset
  localparam int PROD_W = 2 * QUAT_W;
  localparam int MAT_W = 2 * QUAT_W + 2;
  localparam int ENTRY_W = MAT_W - QFRAC;
  localparam int TERM_W = ENTRY_W + VEC_W;
  localparam int SUM_W = TERM_W + 2;
  localparam int ROT_W = SUM_W - QFRAC;
  localparam int OUT_SUM_W = ROT_W + 1;

  // Constants of the matrix formula and rounding
  localparam logic signed [MAT_W-1:0] MAT_ONE = MAT_W'(64'd1 << (2 * QFRAC));
  localparam logic signed [MAT_W-1:0] MAT_HALF = MAT_W'(64'd1 << (QFRAC - 1));
  localparam logic signed [SUM_W-1:0] SUM_HALF = SUM_W'(64'd1 << (QFRAC - 1));

  // Saturation bounds of an output component
  localparam logic signed [VEC_W-1:0] VEC_MAX = {1'b0, {(VEC_W - 1){1'b1}}};
  localparam logic signed [VEC_W-1:0] VEC_MIN = {1'b1, {(VEC_W - 1){1'b0}}};

  // Configuration register map
  localparam int PADDR_W = 3;
  localparam logic REG_OFFSET = 1'b0;

  // Input word
  typedef struct packed {
    logic signed [QUAT_W-1:0] quat_w;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
    logic signed [VEC_W-1:0] vec_x;
    logic signed [VEC_W-1:0] vec_y;
    logic signed [VEC_W-1:0] vec_z;
  } operand_t;

  // Result word
  typedef struct packed {
    logic signed [VEC_W-1:0] out_x;
    logic signed [VEC_W-1:0] out_y;
    logic signed [VEC_W-1:0] out_z;
    logic saturated;
  } result_t;

  // Rounded matrix (row-major, index 3*row+col) and the vector it applies to
  typedef struct packed {
    logic valid;
    logic [8:0][ENTRY_W-1:0] r;
    logic [2:0][VEC_W-1:0] vec;
  } mat_bus_t;

  // Rotated vector before the offset
  typedef struct packed {
    logic valid;
    logic [2:0][ROT_W-1:0] rot;
  } rot_bus_t;

endpackage

[design/qvr_matrix.sv]
// Pairwise quaternion products and rounded rotation matrix (stages 1 and 2).
module qvr_matrix
  import qvr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  operand_t operand,
  output mat_bus_t mat
);

  logic                     v1;
  logic signed [PROD_W-1:0] wx, wy, wz, xx, xy, xz, yy, yz, zz;
  logic [2:0][VEC_W-1:0]    vec1;

  logic signed [MAT_W-1:0]  e_wx, e_wy, e_wz, e_xx, e_xy, e_xz, e_yy, e_yz, e_zz;
  logic signed [MAT_W-1:0]  m [9];
  logic [8:0][ENTRY_W-1:0]  r_next;

  // Round an exact entry to QFRAC fraction bits, half up
  function automatic logic [ENTRY_W-1:0] round_entry(input logic signed [MAT_W-1:0] e);
    logic signed [MAT_W-1:0] t;
    t = e + MAT_HALF;
    return t[MAT_W-1:QFRAC];
  endfunction

  // Stage 1: register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
  end

  // Stage 1: pairwise products, carry the vector along
  always_ff @(posedge clk) begin
    wx <= operand.quat_w * operand.quat_x;
    wy <= operand.quat_w * operand.quat_y;
    wz <= operand.quat_w * operand.quat_z;
    xx <= operand.quat_x * operand.quat_x;
    xy <= operand.quat_x * operand.quat_y;
    xz <= operand.quat_x * operand.quat_z;
    yy <= operand.quat_y * operand.quat_y;
    yz <= operand.quat_y * operand.quat_z;
    zz <= operand.quat_z * operand.quat_z;
    vec1 <= {operand.vec_z, operand.vec_y, operand.vec_x};
  end

  // Stage 2: exact entries with 2*QFRAC fraction bits, then round
  always_comb begin
    e_wx = MAT_W'(wx);
    e_wy = MAT_W'(wy);
    e_wz = MAT_W'(wz);
    e_xx = MAT_W'(xx);
    e_xy = MAT_W'(xy);
    e_xz = MAT_W'(xz);
    e_yy = MAT_W'(yy);
    e_yz = MAT_W'(yz);
    e_zz = MAT_W'(zz);
    m[0] = MAT_ONE - ((e_yy + e_zz) <<< 1);
    m[1] = (e_xy + e_wz) <<< 1;
    m[2] = (e_xz - e_wy) <<< 1;
    m[3] = (e_xy - e_wz) <<< 1;
    m[4] = MAT_ONE - ((e_xx + e_zz) <<< 1);
    m[5] = (e_wx + e_yz) <<< 1;
    m[6] = (e_wy + e_xz) <<< 1;
    m[7] = (e_yz - e_wx) <<< 1;
    m[8] = MAT_ONE - ((e_xx + e_yy) <<< 1);
    for (int k = 0; k < 9; k++) begin
      r_next[k] = round_entry(m[k]);
    end
  end

  // Stage 2: register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      mat.valid <= 1'b0;
    end else begin
      mat.valid <= v1;
    end
  end

  // Stage 2: register matrix and vector
  always_ff @(posedge clk) begin
    mat.r <= r_next;
    mat.vec <= vec1;
  end

endmodule

[design/qvr_mac.sv]
// Matrix-vector multiply and row rounding (stages 3 and 4).
module qvr_mac
  import qvr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mat_bus_t mat,
  output rot_bus_t rot
);

  logic                     v3;
  logic signed [TERM_W-1:0] term [9];
  logic signed [SUM_W-1:0]  row_sum [3];
  logic [2:0][ROT_W-1:0]    rot_next;

  // Stage 3: register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= mat.valid;
    end
  end

  // Stage 3: one product per matrix entry
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        term[3*i+j] <= $signed(mat.r[3*i+j]) * $signed(mat.vec[j]);
      end
    end
  end

  // Stage 4: sum each row exactly, drop QFRAC bits rounding half up
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      row_sum[i] = SUM_W'(term[3*i]) + SUM_W'(term[3*i+1]) + SUM_W'(term[3*i+2])
                   + SUM_HALF;
      rot_next[i] = row_sum[i][SUM_W-1:QFRAC];
    end
  end

  // Stage 4: register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rot.valid <= 1'b0;
    end else begin
      rot.valid <= v3;
    end
  end

  // Stage 4: register rotated vector
  always_ff @(posedge clk) begin
    rot.rot <= rot_next;
  end

endmodule

[design/qvr_out.sv]
// Offset add, saturation and result register (stage 5).
module qvr_out
  import qvr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  rot_bus_t                rot,
  input  logic signed [VEC_W-1:0] offset,
  output logic                    done,
  output result_t                 result
);

  logic signed [OUT_SUM_W-1:0] acc [3];
  logic [2:0][VEC_W-1:0]       comp;
  logic [2:0]                  clip;

  // Add offset and clamp each component to the output range
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = OUT_SUM_W'($signed(rot.rot[i])) + OUT_SUM_W'(offset);
      if (acc[i] > OUT_SUM_W'(VEC_MAX)) begin
        comp[i] = VEC_MAX;
        clip[i] = 1'b1;
      end else if (acc[i] < OUT_SUM_W'(VEC_MIN)) begin
        comp[i] = VEC_MIN;
        clip[i] = 1'b1;
      end else begin
        comp[i] = acc[i][VEC_W-1:0];
        clip[i] = 1'b0;
      end
    end
  end

  // Strobe the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= rot.valid;
    end
  end

  // Register the result word
  always_ff @(posedge clk) begin
    result.out_x <= comp[0];
    result.out_y <= comp[1];
    result.out_z <= comp[2];
    result.saturated <= |clip;
  end

endmodule

[design/quaternion_vector_rotate.sv]
// Top level of the quaternion vector rotator: config register and pipeline.
//
//   channel   handshake                    word
//   -------   --------------------------   ------------------------------
//   input     start (taken when !busy)      operand (quaternion, vector)
//   result    done, one cycle               result (vector, saturated)
//   config    psel/penable/pwrite/pready    offset at byte address 0
//
// One word enters per cycle; busy never rises. Each result appears on
// done after the register stages in order: quaternion products, matrix
// rounding, matrix-vector products, row sums, then offset and saturation,
// one register stage each. Reset clears the stage valid bits and the offset.
// The receiver cannot stall, so the pipeline never holds.
module quaternion_vector_rotate
  import qvr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  operand_t           operand,
  output logic               done,
  output result_t            result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic signed [VEC_W-1:0] offset;
  logic                    reg_sel;
  mat_bus_t                mat;
  rot_bus_t                rot;

  assign busy = 1'b0;
  assign pready = 1'b1;
  assign reg_sel = paddr[2];

  // Write the offset register
  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel == REG_OFFSET) begin
      offset <= pwdata[VEC_W-1:0];
    end
  end

  // Read back the offset register
  always_comb begin
    if (reg_sel == REG_OFFSET) begin
      prdata = 32'(offset);
    end else begin
      prdata = '0;
    end
  end

  qvr_matrix u_matrix (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .operand (operand),
    .mat     (mat)
  );

  qvr_mac u_mac (
    .clk (clk),
    .rst (rst),
    .mat (mat),
    .rot (rot)
  );

  qvr_out u_out (
    .clk    (clk),
    .rst    (rst),
    .rot    (rot),
    .offset (offset),
    .done   (done),
    .result (result)
  );

endmodule

[design/qvr_checker.sv]
// Port-level checks for the quaternion vector rotator, bound to the top level.
module qvr_checker
  import qvr_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    done,
  input result_t result
);

  // Every accepted word yields its result on done
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##5 done)
    else $error("accepted word gave no result after five cycles");

  // No result without a matching accepted word
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 5) && !$past(busy, 5))
    else $error("result without matching accepted word");

  // Reset drops any result in flight
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

  // A saturation flag comes with a component at a bound
  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    done && result.saturated |->
      result.out_x == VEC_MAX || result.out_x == VEC_MIN ||
      result.out_y == VEC_MAX || result.out_y == VEC_MIN ||
      result.out_z == VEC_MAX || result.out_z == VEC_MIN)
    else $error("saturated set with no clipped component");

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

[bench/quaternion_vector_rotate_tb.sv]
// Testbench for the quaternion vector rotator: directed and random words against a predictor.
module quaternion_vector_rotate_tb
  import qvr_pkg::*;
;

  // Byte addresses on the config port: the offset and an unmapped register slot
  localparam logic [PADDR_W-1:0] OFFSET_ADDR = PADDR_W'(REG_OFFSET) << 2;
  localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(4);
  localparam int RANDOM_WORDS_PER_PHASE = 300;
  localparam int NUM_PHASES = 6;
  localparam int OPERAND_W = $bits(operand_t);

  // Predicts rotated vectors and checks each result word against the oldest one
  class rotation_checker;
    logic signed [VEC_W-1:0] offset;
    result_t pending_rotations[$];
    int mismatches;

    function new();
      offset = '0;
      mismatches = 0;
    endfunction

    // Round half up, dropping sh fraction bits
    function longint round_half_up(longint m, int sh);
      return (m + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function result_t rotate(operand_t op);
      longint w, x, y, z, one, acc;
      longint vin[3];
      longint mat[3][3];
      result_t res;
      w = op.quat_w;
      x = op.quat_x;
      y = op.quat_y;
      z = op.quat_z;
      vin[0] = op.vec_x;
      vin[1] = op.vec_y;
      vin[2] = op.vec_z;
      one = longint'(1) <<< (2 * QFRAC);
      // Build the rotation matrix exactly, then round each entry to QFRAC bits
      mat[0][0] = round_half_up(one - 2 * (y * y + z * z), QFRAC);
      mat[0][1] = round_half_up(2 * (x * y + w * z), QFRAC);
      mat[0][2] = round_half_up(2 * (x * z - w * y), QFRAC);
      mat[1][0] = round_half_up(2 * (x * y - w * z), QFRAC);
      mat[1][1] = round_half_up(one - 2 * (x * x + z * z), QFRAC);
      mat[1][2] = round_half_up(2 * (w * x + y * z), QFRAC);
      mat[2][0] = round_half_up(2 * (w * y + x * z), QFRAC);
      mat[2][1] = round_half_up(2 * (y * z - w * x), QFRAC);
      mat[2][2] = round_half_up(one - 2 * (x * x + y * y), QFRAC);
      res.saturated = 1'b0;
      // Sum each row exactly, round to the vector format, add offset, clip
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) begin
          acc += mat[i][j] * vin[j];
        end
        acc = round_half_up(acc, QFRAC) + longint'(offset);
        if (acc > longint'(VEC_MAX)) begin
          acc = longint'(VEC_MAX);
          res.saturated = 1'b1;
        end else if (acc < longint'(VEC_MIN)) begin
          acc = longint'(VEC_MIN);
          res.saturated = 1'b1;
        end
        case (i)
          0: res.out_x = acc[VEC_W-1:0];
          1: res.out_y = acc[VEC_W-1:0];
          default: res.out_z = acc[VEC_W-1:0];
        endcase
      end
      return res;
    endfunction

    function void note_operand(operand_t op);
      pending_rotations.push_back(rotate(op));
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_rotations.size() == 0) begin
        $error("result word with no rotation pending: got %h", got);
        mismatches++;
        return;
      end
      want = pending_rotations.pop_front();
      compare_field("out_x", want.out_x, got.out_x);
      compare_field("out_y", want.out_y, got.out_y);
      compare_field("out_z", want.out_z, got.out_z);
      compare_field("saturated", want.saturated, got.saturated);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  operand_t operand = '0;
  logic done;
  result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  rotation_checker checker_q = new();

  quaternion_vector_rotate uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operand(operand),
    .done(done),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #10 clk = ~clk;

  // Check every result word as the strobe marks it
  always @(posedge clk) begin
    if (!rst && done) begin
      checker_q.check_result(result);
    end
  end

  // Present one word after a random gap, hold it until taken
  task automatic send_operand(operand_t op, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    operand <= op;
    do @(posedge clk); while (busy);
    checker_q.note_operand(op);
  endtask

  task automatic send_directed(int w, int x, int y, int z, int vx, int vy, int vz);
    operand_t op;
    op.quat_w = w[QUAT_W-1:0];
    op.quat_x = x[QUAT_W-1:0];
    op.quat_y = y[QUAT_W-1:0];
    op.quat_z = z[QUAT_W-1:0];
    op.vec_x = vx;
    op.vec_y = vy;
    op.vec_z = vz;
    send_operand(op, 0);
  endtask

  // Write one config register through a setup and an access phase
  task automatic write_reg(logic [PADDR_W-1:0] addr, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == OFFSET_ADDR) begin
      checker_q.offset = value;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Stop sending and wait until every pending rotation has come back
  task automatic drain();
    start <= 1'b0;
    while (checker_q.pending_rotations.size() != 0) @(posedge clk);
  endtask

  function automatic logic [QUAT_W-1:0] pick_quat();
    case ($urandom_range(5))
      0: return {1'b1, {(QUAT_W - 1){1'b0}}};
      1: return {1'b0, {(QUAT_W - 1){1'b1}}};
      2: return '0;
      3: return '1;
      4: return QUAT_W'(1) << QFRAC;
      default: return QUAT_W'($urandom);
    endcase
  endfunction

  function automatic logic [VEC_W-1:0] pick_vec();
    case ($urandom_range(5))
      0: return VEC_MIN;
      1: return VEC_MAX;
      2: return '0;
      3: return '1;
      4: return VEC_W'($urandom_range(1 << 17)) - VEC_W'(1 << 16);
      default: return VEC_W'($urandom);
    endcase
  endfunction

  // Mix full-range words, quaternions with fields in [-1, 1], edge values and small vectors
  function automatic operand_t random_operand();
    operand_t op;
    int mode;
    mode = $urandom_range(9);
    op = OPERAND_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    if (mode == 5 || mode == 6) begin
      op.quat_w = QUAT_W'($urandom_range(32768)) - QUAT_W'(16384);
      op.quat_x = QUAT_W'($urandom_range(32768)) - QUAT_W'(16384);
      op.quat_y = QUAT_W'($urandom_range(32768)) - QUAT_W'(16384);
      op.quat_z = QUAT_W'($urandom_range(32768)) - QUAT_W'(16384);
    end else if (mode == 7) begin
      op.quat_w = pick_quat();
      op.quat_x = pick_quat();
      op.quat_y = pick_quat();
      op.quat_z = pick_quat();
      op.vec_x = pick_vec();
      op.vec_y = pick_vec();
      op.vec_z = pick_vec();
    end else if (mode >= 8) begin
      op.vec_x = VEC_W'($urandom_range(1 << 21)) - VEC_W'(1 << 20);
      op.vec_y = VEC_W'($urandom_range(1 << 21)) - VEC_W'(1 << 20);
      op.vec_z = VEC_W'($urandom_range(1 << 21)) - VEC_W'(1 << 20);
    end
    return op;
  endfunction

  initial begin
    int idle_pct;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words under the reset offset
    // identity rotation, extreme and rounding-sensitive vectors
    send_directed(16384, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_directed(16384, 0, 0, 0, 1, -1, 65536);
    // zero quaternion still leaves the identity from the constant terms
    send_directed(0, 0, 0, 0, 12345678, -87654321, 1);
    // quarter turns about each axis
    send_directed(11585, 0, 0, 11585, 65536, 131072, -196608);
    send_directed(11585, 11585, 0, 0, 65536, 131072, -196608);
    send_directed(11585, 0, 11585, 0, 65536, 131072, -196608);
    // half turn about x
    send_directed(0, 16384, 0, 0, 1000, 2000, 3000);
    // all extremes of the quaternion fields
    send_directed(32767, 32767, 32767, 32767, 65536, 65536, 65536);
    send_directed(-32768, -32768, -32768, -32768, -65536, 65536, -65536);
    send_directed(-32768, 32767, -32768, 32767, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_directed(32767, -32768, 32767, -32768, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    // non-unit quaternion that scales the vector, then a unit one with equal fields
    send_directed(23170, 0, 23170, 0, 100000, -100000, 50000);
    send_directed(8192, 8192, 8192, 8192, 777777, 333333, -999999);
    // overflow both ways through a scaling matrix
    send_directed(0, 32767, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_directed(0, 0, 32767, 32767, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    // all-ones fields and odd vector low bits for rounding
    send_directed(-1, -1, -1, -1, -1, -1, -1);
    send_directed(11585, 5793, -5793, 1, 8191, 8192, 16383);
    send_directed(1, 16383, -16383, 2, 24575, -8193, 3);
    send_directed(16384, 16384, 16384, 16384, 0, 0, 0);
    drain();

    // Random phases, each under its own offset and sender idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          write_reg(OFFSET_ADDR, 32'h0000_0000);
          idle_pct = 0;
        end
        1: begin
          write_reg(OFFSET_ADDR, 32'h7FFF_FFFF);
          idle_pct = 81;
        end
        2: begin
          write_reg(OFFSET_ADDR, 32'h8000_0000);
          idle_pct = 0;
        end
        3: begin
          write_reg(OFFSET_ADDR, $urandom);
          idle_pct = 17;
        end
        4: begin
          // unmapped register: the offset must not move
          write_reg(OFFSET_ADDR, $urandom_range(1 << 20) - (1 << 19));
          @(posedge clk);
          write_reg(SPARE_ADDR, $urandom);
          idle_pct = 81;
        end
        default: begin
          write_reg(OFFSET_ADDR, 32'hFFFF_0000);
          idle_pct = 0;
        end
      endcase
      for (int n = 0; n < RANDOM_WORDS_PER_PHASE; n++) begin
        send_operand(random_operand(), idle_pct);
      end
      drain();
    end

    // Let the pipeline settle, then report
    repeat (10) @(posedge clk);
    if (checker_q.mismatches == 0 && checker_q.pending_rotations.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop in case the block hangs
  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

[quaternion_vector_rotate.f]
design/qvr_pkg.sv
design/qvr_matrix.sv
design/qvr_mac.sv
design/qvr_out.sv
design/quaternion_vector_rotate.sv
design/qvr_checker.sv
bench/quaternion_vector_rotate_tb.sv
